[rtl/core/aavr_pkg.sv]
package aavr_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 24;
  localparam int unsigned CW = 33;
  localparam int unsigned DW = 33;
  localparam int unsigned MW = 30;

  localparam logic signed [ZW-1:0] AngPi = ZW'(3294199);
  localparam logic signed [ZW-1:0] AngHalfPi = ZW'(1647099);
  localparam logic signed [XW-1:0] CordicGain = XW'(652032874);

  localparam logic signed [ZW-1:0] AtanTab [CordicSteps] = '{
    ZW'(823550), ZW'(486170), ZW'(256879), ZW'(130396), ZW'(65451),
    ZW'(32757), ZW'(16383), ZW'(8192), ZW'(4096), ZW'(2048),
    ZW'(1024), ZW'(512), ZW'(256), ZW'(128), ZW'(64),
    ZW'(32), ZW'(16), ZW'(8), ZW'(4), ZW'(2)
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
    logic signed [31:0]   ex;
    logic signed [31:0]   ey;
    logic signed [31:0]   ez;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } cordic_t;

endpackage

[rtl/core/aavr_if.sv]
interface aavr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (output valid, angle, axis_x, axis_y, axis_z, eye_x, eye_y, eye_z,
                  target_x, target_y, target_z, input ready);
  modport sink (input valid, angle, axis_x, axis_y, axis_z, eye_x, eye_y, eye_z,
                target_x, target_y, target_z, output ready);
endinterface

interface aavr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_target_x;
  logic signed [31:0] new_target_y;
  logic signed [31:0] new_target_z;

  modport source (output valid, new_target_x, new_target_y, new_target_z, input ready);
  modport sink (input valid, new_target_x, new_target_y, new_target_z, output ready);
endinterface

[rtl/core/aavr_cordic.sv]
module aavr_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aavr_pkg::cordic_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aavr_pkg::cordic_t out_data_o
);
  import aavr_pkg::*;

  cordic_t st_q [CordicSteps];
  logic    v_q  [CordicSteps];
  logic    en   [CordicSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_stage
    cordic_t cur;
    cordic_t st_d;
    logic    vin;

    if (k == 0) begin : g_first
      assign cur = in_data_i;
      assign vin = in_valid_i;
    end else begin : g_next
      assign cur = st_q[k-1];
      assign vin = v_q[k-1];
    end

    if (k == CordicSteps - 1) begin : g_last
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      st_d = cur;
      if (!cur.z[ZW-1]) begin
        st_d.x = cur.x - (cur.y >>> k);
        st_d.y = cur.y + (cur.x >>> k);
        st_d.z = cur.z - AtanTab[k];
      end else begin
        st_d.x = cur.x + (cur.y >>> k);
        st_d.y = cur.y - (cur.x >>> k);
        st_d.z = cur.z + AtanTab[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[CordicSteps-1];
  assign out_data_o  = st_q[CordicSteps-1];

endmodule

[rtl/core/axis_angle_view_rotation.sv]
// axis-angle rotation of a camera look-at point about its eye point
// input channel in_i: angle (Q3.13 rad), unit axis (Q2.14), eye and target (Q16.16)
// output channel out_o: new target = eye + R * (target - eye), saturated Q16.16
// both channels move an item when valid and ready are high at a clock edge
// the pipeline has one range-reduction stage, 20 cordic stages, one stage for
// sin/cos and axis products, two stages forming the nine matrix terms, one stage
// of matrix-vector products and one stage of sums, rounding and saturation
// throughput is one item per cycle without stalls; every stage holds its own valid
// bit, so the pipeline keeps taking items while a finished result waits in the
// output register and only stalls back to the input once each stage holds an item
// a stalled receiver freezes the output register and full stages directly behind it
// reset clears all valid bits; payload registers are not reset

module axis_angle_view_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  aavr_in_if.sink     in_i,
  aavr_out_if.source  out_o
);
  import aavr_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] omc;
    logic signed [31:0]   pxx;
    logic signed [31:0]   pxy;
    logic signed [31:0]   pxz;
    logic signed [31:0]   pyy;
    logic signed [31:0]   pyz;
    logic signed [31:0]   pzz;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
    logic signed [31:0]   ex;
    logic signed [31:0]   ey;
    logic signed [31:0]   ez;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } trig_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [63:0]   oxx;
    logic signed [63:0]   oxy;
    logic signed [63:0]   oxz;
    logic signed [63:0]   oyy;
    logic signed [63:0]   oyz;
    logic signed [63:0]   ozz;
    logic signed [48:0]   sx;
    logic signed [48:0]   sy;
    logic signed [48:0]   sz;
    logic signed [31:0]   ex;
    logic signed [31:0]   ey;
    logic signed [31:0]   ez;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } prod_t;

  typedef struct packed {
    logic [8:0][MW-1:0]   m;
    logic signed [31:0]   ex;
    logic signed [31:0]   ey;
    logic signed [31:0]   ez;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } mat_t;

  typedef struct packed {
    logic [8:0][63:0]   p;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
  } mv_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } res_t;

  function automatic logic signed [MW-1:0] rnd34(input logic signed [63:0] t);
    logic signed [63:0] r;
    r = t + (64'sd1 <<< 33);
    return r[63:34];
  endfunction

  function automatic logic signed [31:0] finish(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic signed [63:0] c,
                                                input logic signed [31:0] e);
    logic signed [63:0] sum;
    logic signed [39:0] r;
    logic signed [40:0] tot;
    logic signed [40:0] ew;
    sum = a + b + c + (64'sd1 <<< 23);
    r   = sum[63:24];
    ew  = 41'(e);
    tot = 41'(r) + ew;
    if (tot > 41'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (tot < -41'sd2147483648) begin
      return 32'sh80000000;
    end
    return tot[31:0];
  endfunction

  // range reduction stage
  cordic_t            pre_d, pre_q;
  logic               pre_v_q, en_pre;
  logic signed [ZW-1:0] z0;

  logic    cor_in_ready, cor_v;
  cordic_t cor_q;

  trig_t f_d, f_q;
  logic  f_v_q, en_f;
  prod_t m1_d, m1_q;
  logic  m1_v_q, en_m1;
  mat_t  m2_d, m2_q;
  logic  m2_v_q, en_m2;
  mv_t   m3_d, m3_q;
  logic  m3_v_q, en_m3;
  res_t  o_d, o_q;
  logic  o_v_q, en_o;

  assign en_o   = !o_v_q || out_o.ready;
  assign en_m3  = !m3_v_q || en_o;
  assign en_m2  = !m2_v_q || en_m3;
  assign en_m1  = !m1_v_q || en_m2;
  assign en_f   = !f_v_q || en_m1;
  assign en_pre = !pre_v_q || cor_in_ready;

  assign in_i.ready = en_pre;

  always_comb begin
    z0 = {in_i.angle[15], in_i.angle, 7'b0};
    pre_d.flip = 1'b0;
    pre_d.z    = z0;
    if (z0 > AngHalfPi) begin
      pre_d.z    = z0 - AngPi;
      pre_d.flip = 1'b1;
    end else if (z0 < -AngHalfPi) begin
      pre_d.z    = z0 + AngPi;
      pre_d.flip = 1'b1;
    end
    pre_d.x  = CordicGain;
    pre_d.y  = '0;
    pre_d.ax = in_i.axis_x;
    pre_d.ay = in_i.axis_y;
    pre_d.az = in_i.axis_z;
    pre_d.ex = in_i.eye_x;
    pre_d.ey = in_i.eye_y;
    pre_d.ez = in_i.eye_z;
    pre_d.dx = {in_i.target_x[31], in_i.target_x} - {in_i.eye_x[31], in_i.eye_x};
    pre_d.dy = {in_i.target_y[31], in_i.target_y} - {in_i.eye_y[31], in_i.eye_y};
    pre_d.dz = {in_i.target_z[31], in_i.target_z} - {in_i.eye_z[31], in_i.eye_z};
  end

  aavr_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_v_q),
    .in_ready_o  (cor_in_ready),
    .in_data_i   (pre_q),
    .out_valid_o (cor_v),
    .out_ready_i (en_f),
    .out_data_o  (cor_q)
  );

  // sin, cos and axis products
  always_comb begin
    logic signed [XW-1:0] cx, sy;
    cx = cor_q.flip ? -cor_q.x : cor_q.x;
    sy = cor_q.flip ? -cor_q.y : cor_q.y;
    f_d.c   = cx[CW-1:0];
    f_d.s   = sy[CW-1:0];
    f_d.omc = (CW'(1) <<< 30) - cx[CW-1:0];
    f_d.pxx = cor_q.ax * cor_q.ax;
    f_d.pxy = cor_q.ax * cor_q.ay;
    f_d.pxz = cor_q.ax * cor_q.az;
    f_d.pyy = cor_q.ay * cor_q.ay;
    f_d.pyz = cor_q.ay * cor_q.az;
    f_d.pzz = cor_q.az * cor_q.az;
    f_d.ax  = cor_q.ax;
    f_d.ay  = cor_q.ay;
    f_d.az  = cor_q.az;
    f_d.ex  = cor_q.ex;
    f_d.ey  = cor_q.ey;
    f_d.ez  = cor_q.ez;
    f_d.dx  = cor_q.dx;
    f_d.dy  = cor_q.dy;
    f_d.dz  = cor_q.dz;
  end

  always_comb begin
    m1_d.c   = f_q.c;
    m1_d.oxx = f_q.omc * f_q.pxx;
    m1_d.oxy = f_q.omc * f_q.pxy;
    m1_d.oxz = f_q.omc * f_q.pxz;
    m1_d.oyy = f_q.omc * f_q.pyy;
    m1_d.oyz = f_q.omc * f_q.pyz;
    m1_d.ozz = f_q.omc * f_q.pzz;
    m1_d.sx  = f_q.s * f_q.ax;
    m1_d.sy  = f_q.s * f_q.ay;
    m1_d.sz  = f_q.s * f_q.az;
    m1_d.ex  = f_q.ex;
    m1_d.ey  = f_q.ey;
    m1_d.ez  = f_q.ez;
    m1_d.dx  = f_q.dx;
    m1_d.dy  = f_q.dy;
    m1_d.dz  = f_q.dz;
  end

  // matrix terms, rounded to q.24
  always_comb begin
    logic signed [63:0] c28, sx14, sy14, sz14;
    c28  = 64'(m1_q.c);
    c28  = c28 <<< 28;
    sx14 = 64'(m1_q.sx);
    sx14 = sx14 <<< 14;
    sy14 = 64'(m1_q.sy);
    sy14 = sy14 <<< 14;
    sz14 = 64'(m1_q.sz);
    sz14 = sz14 <<< 14;
    m2_d.m[0] = rnd34(m1_q.oxx + c28);
    m2_d.m[1] = rnd34(m1_q.oxy - sz14);
    m2_d.m[2] = rnd34(m1_q.oxz + sy14);
    m2_d.m[3] = rnd34(m1_q.oxy + sz14);
    m2_d.m[4] = rnd34(m1_q.oyy + c28);
    m2_d.m[5] = rnd34(m1_q.oyz - sx14);
    m2_d.m[6] = rnd34(m1_q.oxz - sy14);
    m2_d.m[7] = rnd34(m1_q.oyz + sx14);
    m2_d.m[8] = rnd34(m1_q.ozz + c28);
    m2_d.ex   = m1_q.ex;
    m2_d.ey   = m1_q.ey;
    m2_d.ez   = m1_q.ez;
    m2_d.dx   = m1_q.dx;
    m2_d.dy   = m1_q.dy;
    m2_d.dz   = m1_q.dz;
  end

  always_comb begin
    logic signed [63:0] pr;
    for (int i = 0; i < 9; i++) begin
      case (i % 3)
        0:       pr = $signed(m2_q.m[i]) * m2_q.dx;
        1:       pr = $signed(m2_q.m[i]) * m2_q.dy;
        default: pr = $signed(m2_q.m[i]) * m2_q.dz;
      endcase
      m3_d.p[i] = pr;
    end
    m3_d.ex = m2_q.ex;
    m3_d.ey = m2_q.ey;
    m3_d.ez = m2_q.ez;
  end

  always_comb begin
    o_d.x = finish($signed(m3_q.p[0]), $signed(m3_q.p[1]), $signed(m3_q.p[2]), m3_q.ex);
    o_d.y = finish($signed(m3_q.p[3]), $signed(m3_q.p[4]), $signed(m3_q.p[5]), m3_q.ey);
    o_d.z = finish($signed(m3_q.p[6]), $signed(m3_q.p[7]), $signed(m3_q.p[8]), m3_q.ez);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
      f_v_q   <= 1'b0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m3_v_q  <= 1'b0;
      o_v_q   <= 1'b0;
    end else begin
      if (en_pre) pre_v_q <= in_i.valid;
      if (en_f)   f_v_q   <= cor_v;
      if (en_m1)  m1_v_q  <= f_v_q;
      if (en_m2)  m2_v_q  <= m1_v_q;
      if (en_m3)  m3_v_q  <= m2_v_q;
      if (en_o)   o_v_q   <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_pre) pre_q <= pre_d;
    if (en_f)   f_q   <= f_d;
    if (en_m1)  m1_q  <= m1_d;
    if (en_m2)  m2_q  <= m2_d;
    if (en_m3)  m3_q  <= m3_d;
    if (en_o)   o_q   <= o_d;
  end

  assign out_o.valid        = o_v_q;
  assign out_o.new_target_x = o_q.x;
  assign out_o.new_target_y = o_q.y;
  assign out_o.new_target_z = o_q.z;

  // reduced angle stays within a quarter turn
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_v_q |-> (pre_q.z <= AngHalfPi) && (pre_q.z >= -AngHalfPi))
    else $error("angle reduction out of range");

  // cosine after sign flip stays within 1 + 2^-10 in magnitude
  a_cos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> (f_q.c <= $signed((CW'(1) <<< 30) + (CW'(1) <<< 20))) &&
              (f_q.c >= -$signed((CW'(1) <<< 30) + (CW'(1) <<< 20))))
    else $error("cosine out of range");

  // a stalled output holds the stage behind it
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && !out_o.ready && m3_v_q) |=> m3_v_q && $stable(m3_q))
    else $error("matrix product stage lost an item under stall");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } view_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  localparam longint AngPiQ20 = 3294199;
  localparam longint AngHalfPiQ20 = 1647099;
  localparam longint GainQ30 = 652032874;
  localparam int Limit = 400000;
  localparam int DrainCycles = 60;

  localparam longint AtanQ20 [20] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  logic clk;
  logic rst_n;
  aavr_in_if in_if ();
  aavr_out_if out_if ();

  axis_angle_view_rotation DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  view_item_t pending_items[$];
  point_t     expected_targets[$];
  int         errors;
  int         cycles;
  bit         stim_done;
  bit         in_taken;
  int         send_gap;
  int         stall_left;
  bit         send_burst;
  bit         recv_burst;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint matrix_term(longint c, longint omc, longint ai, longint aj,
                                         longint sak, bit diag);
    longint t;
    t = omc * (ai * aj);
    if (diag) t += c * (longint'(1) <<< 28);
    else t += sak * (longint'(1) <<< 14);
    return rshift_round(t, 34);
  endfunction

  function automatic point_t rotate_target(view_item_t it);
    longint z, x, y, nx, c, s, omc, ax, ay, az, dx, dy, dz;
    longint m [9];
    bit flip;
    point_t r;
    z = longint'(it.angle) * 128;
    x = GainQ30;
    y = 0;
    flip = 0;
    if (z > AngHalfPiQ20) begin
      z -= AngPiQ20;
      flip = 1;
    end else if (z < -AngHalfPiQ20) begin
      z += AngPiQ20;
      flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= AtanQ20[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += AtanQ20[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
    omc = (longint'(1) <<< 30) - c;
    ax = it.ax; ay = it.ay; az = it.az;
    dx = longint'(it.tx) - longint'(it.ex);
    dy = longint'(it.ty) - longint'(it.ey);
    dz = longint'(it.tz) - longint'(it.ez);
    m[0] = matrix_term(c, omc, ax, ax, 0, 1);
    m[1] = matrix_term(c, omc, ax, ay, -(s * az), 0);
    m[2] = matrix_term(c, omc, ax, az, s * ay, 0);
    m[3] = matrix_term(c, omc, ax, ay, s * az, 0);
    m[4] = matrix_term(c, omc, ay, ay, 0, 1);
    m[5] = matrix_term(c, omc, ay, az, -(s * ax), 0);
    m[6] = matrix_term(c, omc, ax, az, -(s * ay), 0);
    m[7] = matrix_term(c, omc, ay, az, s * ax, 0);
    m[8] = matrix_term(c, omc, az, az, 0, 1);
    r.x = clamp32(longint'(it.ex) + rshift_round(m[0] * dx + m[1] * dy + m[2] * dz, 24));
    r.y = clamp32(longint'(it.ey) + rshift_round(m[3] * dx + m[4] * dy + m[5] * dz, 24));
    r.z = clamp32(longint'(it.ez) + rshift_round(m[6] * dx + m[7] * dy + m[8] * dz, 24));
    return r;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_axis_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'sd16384;
    if (r < 6) return -16'sd16384;
    if (r < 8) return 16'($urandom_range(0, 32767)) - 16'sd16384;
    return 16'($urandom);
  endfunction

  function automatic logic signed [31:0] rand_coord(bit wide);
    if (wide) return 32'($urandom);
    return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
  endfunction

  task automatic add_item(logic signed [15:0] angle, logic signed [15:0] ax,
                          logic signed [15:0] ay, logic signed [15:0] az,
                          logic signed [31:0] ex, logic signed [31:0] ey,
                          logic signed [31:0] ez, logic signed [31:0] tx,
                          logic signed [31:0] ty, logic signed [31:0] tz);
    view_item_t it;
    it.angle = angle; it.ax = ax; it.ay = ay; it.az = az;
    it.ex = ex; it.ey = ey; it.ez = ez;
    it.tx = tx; it.ty = ty; it.tz = tz;
    pending_items.push_back(it);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int r;
    view_item_t it;
    // directed: angle extremes, range-reduction edges, axis extremes, saturation
    add_item(0, 16384, 0, 0, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000);
    add_item(12867, 0, 0, 16384, 0, 0, 0, 32'h10000, 0, 0);
    add_item(12868, 0, 0, 16384, 0, 0, 0, 32'h10000, 0, 0);
    add_item(-12867, 0, 16384, 0, 0, 0, 0, 0, 0, 32'h10000);
    add_item(-12868, 0, 16384, 0, 0, 0, 0, 0, 0, 32'h10000);
    add_item(32767, 16384, 0, 0, 32'h100, 32'h200, 32'h300, 0, 32'h50000, 0);
    add_item(-32768, 0, 0, 16384, 0, 0, 0, 32'h10000, 32'h10000, 0);
    add_item(25736, 9459, 9459, 9459, 32'h11111, -32'sh22222, 32'h33333, 0, 0, 0);
    add_item(6434, 32767, 32767, 32767, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    add_item(-6434, -32768, -32768, -32768, 0, 0, 0, 32'h10000, -32'sh10000, 32'h10000);
    add_item(100, -32768, 32767, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000);
    add_item(-100, 32767, -32768, 0, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_item(0, 16384, 16384, 16384, 32'h7fffffff, 32'h80000000, 0,
             32'h80000000, 32'h7fffffff, 32'h7fffffff);
    add_item(12868, 0, 0, 0, 32'h7ff00000, 32'h80000000, 0, 32'h7fffffff, 0, 0);
    add_item(0, 0, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0);
    add_item(-32768, 16384, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff);
    add_item(32767, -16384, -16384, 32767, 32'h55555555, 32'haaaaaaaa, 32'h12345678,
             32'haaaaaaaa, 32'h55555555, 32'hedcba987);
    add_item(1, 0, 16384, 0, -32'sd1, -32'sd1, -32'sd1, 32'h7fffffff, 0, 32'h80000000);
    for (int n = 0; n < 850; n++) begin
      r = $urandom_range(0, 9);
      it.angle = 16'($urandom);
      it.ax = rand_axis_comp();
      it.ay = rand_axis_comp();
      it.az = rand_axis_comp();
      it.ex = rand_coord(r >= 7);
      it.ey = rand_coord(r >= 7);
      it.ez = rand_coord(r >= 7);
      it.tx = rand_coord(r >= 8);
      it.ty = rand_coord(r >= 8);
      it.tz = rand_coord(r >= 8);
      pending_items.push_back(it);
    end
    stim_done = 1;
  end

  initial begin
    errors = 0;
    cycles = 0;
    in_taken = 0;
    send_gap = 0;
    stall_left = 0;
    send_burst = 0;
    recv_burst = 0;
    in_if.valid = 0;
    in_if.angle = 0;
    in_if.axis_x = 0;
    in_if.axis_y = 0;
    in_if.axis_z = 0;
    in_if.eye_x = 0;
    in_if.eye_y = 0;
    in_if.eye_z = 0;
    in_if.target_x = 0;
    in_if.target_y = 0;
    in_if.target_z = 0;
    out_if.ready = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
  end

  // driver
  always @(negedge clk) begin
    view_item_t it;
    if (rst_n) begin
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      if (!in_if.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_if.angle <= it.angle;
          in_if.axis_x <= it.ax;
          in_if.axis_y <= it.ay;
          in_if.axis_z <= it.az;
          in_if.eye_x <= it.ex;
          in_if.eye_y <= it.ey;
          in_if.eye_z <= it.ez;
          in_if.target_x <= it.tx;
          in_if.target_y <= it.ty;
          in_if.target_z <= it.tz;
          in_if.valid <= 1;
          send_gap = pick_gap(send_burst);
        end else begin
          in_if.valid <= 0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= 1;
        stall_left = pick_gap(recv_burst);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    view_item_t it;
    point_t want;
    cycles++;
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_targets.size() == 0) begin
        $error("new target item with nothing expected");
        errors++;
      end else begin
        want = expected_targets.pop_front();
        if (out_if.new_target_x !== want.x) begin
          $error("new_target_x expected %0d got %0d", want.x, out_if.new_target_x);
          errors++;
        end
        if (out_if.new_target_y !== want.y) begin
          $error("new_target_y expected %0d got %0d", want.y, out_if.new_target_y);
          errors++;
        end
        if (out_if.new_target_z !== want.z) begin
          $error("new_target_z expected %0d got %0d", want.z, out_if.new_target_z);
          errors++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      it.angle = in_if.angle;
      it.ax = in_if.axis_x;
      it.ay = in_if.axis_y;
      it.az = in_if.axis_z;
      it.ex = in_if.eye_x;
      it.ey = in_if.eye_y;
      it.ez = in_if.eye_z;
      it.tx = in_if.target_x;
      it.ty = in_if.target_y;
      it.tz = in_if.target_z;
      expected_targets.push_back(rotate_target(it));
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_items.size() == 0 && !in_if.valid && expected_targets.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (expected_targets.size() != 0) begin
      $error("%0d new target items never arrived", expected_targets.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (cycles >= Limit);
    $error("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[axis_angle_view_rotation.f]
rtl/core/aavr_pkg.sv
rtl/core/aavr_if.sv
rtl/core/aavr_cordic.sv
rtl/core/axis_angle_view_rotation.sv
tb/tb_top.sv
